[hw/rtl/tilt_complementary_filter_core_macros.svh]
// ----------------------------------------------------------------------------
// Tilt filter assertion macros
// Shared concurrent check shorthands, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_MACROS_SVH

// same-cycle implication, ignored while in reset
`define TCF_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define TCF_ASSERT_AFTER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tcf_pkg.sv]
// ----------------------------------------------------------------------------
// Tilt filter package
// Widths, constants, arctangent table and beat types for the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

  // defaults for the top-level parameters
  localparam int DEF_CORDIC_STEPS    = 16;
  localparam int DEF_ANGLE_FRAC_BITS = 8;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int RAW_W    = 16;
  localparam int FILT_W   = 24;
  localparam int K_W      = 17;
  localparam int GAIN_W   = 24;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 1'd1;
  localparam logic [K_W-1:0]       BLEND_WEIGHT_RST = 17'd6554;
  localparam logic [GAIN_W-1:0]    GYRO_GAIN_RST    = 24'd10240;
  localparam logic [K_W-1:0]       K_ONE            = 17'd65536;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // CORDIC datapath
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;
  localparam int ATAN_W    = 22;
  localparam int TAB_FRAC  = 16;
  localparam int PRE_SHIFT = 8;
  localparam int CW        = 27;   // x/y magnitude stays below 2^25
  localparam int ANG_W     = 25;   // accumulated angle, deg * 2^16

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  localparam logic [ATAN_W-1:0] ATAN_TAB [TAB_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // filter saturation bounds
  localparam logic signed [FILT_W-1:0] FILT_MAX = 24'sh7FFFFF;
  localparam logic signed [FILT_W-1:0] FILT_MIN = 24'sh800000;

  // input beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] rate_x;
    logic signed [SAMPLE_W-1:0] rate_y;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic signed [RAW_W-1:0]  tilt_x_raw;
    logic signed [FILT_W-1:0] tilt_x_filtered;
    logic signed [RAW_W-1:0]  tilt_y_raw;
    logic signed [FILT_W-1:0] tilt_y_filtered;
    logic                     clipped;
  } out_item_t;

  // classified sample: z folded into the right half plane of the CORDIC
  typedef struct packed {
    logic                       z_zero;
    logic [SAMPLE_W-1:0]        z_mag;
    logic signed [SAMPLE_W:0]   ax_fold;
    logic signed [SAMPLE_W:0]   ay_fold;
    logic signed [SAMPLE_W-1:0] rate_x;
    logic signed [SAMPLE_W-1:0] rate_y;
  } cmd_t;

  // back sequencer to lane
  typedef struct packed {
    logic start;
    logic retire;
  } lane_ctl_t;

  // lane to back sequencer
  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

endpackage

[hw/rtl/tcf_fifo.sv]
// ----------------------------------------------------------------------------
// Tilt filter command queue
// Short first-word-fall-through queue between the front and the back.
// ----------------------------------------------------------------------------
module tcf_fifo import tcf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  cmd_t wdata,
  input  logic pop,
  output logic empty,
  output cmd_t rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/tcf_front.sv]
// ----------------------------------------------------------------------------
// Tilt filter front end
// Takes sample beats, folds z into the right half plane and queues them.
// ----------------------------------------------------------------------------
module tcf_front import tcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     q_push,
  input  logic     q_full,
  output cmd_t     q_data
);

  logic     stage_v_r, stage_v_nxt;
  cmd_t     stage_r, stage_nxt;
  logic     accept;
  logic     z_neg;

  assign in_full = stage_v_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = stage_v_r && !q_full;
  assign q_data  = stage_r;

  // classify: zero z, |z|, and accel mirrored by sign of z
  assign z_neg = in_data.accel_z[SAMPLE_W-1];
  always_comb begin
    stage_nxt.z_zero  = (in_data.accel_z == '0);
    stage_nxt.z_mag   = z_neg ? SAMPLE_W'(-in_data.accel_z) : in_data.accel_z;
    stage_nxt.ax_fold = z_neg ? -(SAMPLE_W + 1)'(in_data.accel_x)
                              : (SAMPLE_W + 1)'(in_data.accel_x);
    stage_nxt.ay_fold = z_neg ? -(SAMPLE_W + 1)'(in_data.accel_y)
                              : (SAMPLE_W + 1)'(in_data.accel_y);
    stage_nxt.rate_x  = in_data.rate_x;
    stage_nxt.rate_y  = in_data.rate_y;
  end

  // stage occupancy
  always_comb begin
    stage_v_nxt = stage_v_r;
    if (accept) begin
      stage_v_nxt = 1'b1;
    end else if (q_push) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

[hw/rtl/tcf_lane.sv]
// ----------------------------------------------------------------------------
// Tilt filter axis lane
// Iterative CORDIC tilt for one axis, then the complementary blend.
// ----------------------------------------------------------------------------
module tcf_lane import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctl_t                  ctl,
  output lane_sts_t                  sts,
  input  logic                       z_zero,
  input  logic [SAMPLE_W-1:0]        z_mag,
  input  logic signed [SAMPLE_W:0]   a_fold,
  input  logic signed [SAMPLE_W-1:0] rate,
  input  logic [K_W-1:0]             k_eff,
  input  logic [GAIN_W-1:0]          gain,
  output logic signed [RAW_W-1:0]    tilt_raw,
  output logic signed [FILT_W-1:0]   filt,
  output logic                       clip
);

  // derived widths
  localparam int TILT_W = ANGLE_FRAC_BITS + 8;
  localparam int SH     = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int RG_W   = SAMPLE_W + GAIN_W + 1;
  localparam int S2_W   = FILT_W + 17;
  localparam int KT_W   = TILT_W + K_W + 1;
  localparam int T_W    = ((KT_W > S2_W) ? KT_W : S2_W) + 1;
  localparam int KLO_W  = K_W + 24;
  localparam int KHI_W  = K_W + 1 + S2_W - 24;
  localparam int ACC_W  = (((T_W + 16) > (KHI_W + 24)) ? (T_W + 16) : (KHI_W + 24)) + 2;
  localparam int R_W    = ACC_W - 32;

  localparam logic signed [ANG_W-1:0] ANG_LIM  = ANG_W'(90 * (1 << TAB_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'((1 << SH) >> 1);
  localparam logic signed [ANG_W-1:0] TILT_LIM = ANG_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'h8000_0000);
  localparam logic [TAB_IDX_W-1:0]    LAST_IT  = TAB_IDX_W'(CORDIC_STEPS - 1);

  // sequencer codes
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_ITER  = 4'd1;
  localparam logic [ST_W-1:0] ST_ROUND = 4'd2;
  localparam logic [ST_W-1:0] ST_MUL1  = 4'd3;
  localparam logic [ST_W-1:0] ST_MUL2  = 4'd4;
  localparam logic [ST_W-1:0] ST_MUL3  = 4'd5;
  localparam logic [ST_W-1:0] ST_ACC   = 4'd6;
  localparam logic [ST_W-1:0] ST_SAT   = 4'd7;
  localparam logic [ST_W-1:0] ST_DONE  = 4'd8;

  logic [ST_W-1:0]             state_r, state_nxt;
  logic [TAB_IDX_W-1:0]        cnt_r, cnt_nxt;
  logic signed [FILT_W-1:0]    old_r, old_nxt;
  logic                        zero_r, zero_nxt;
  logic signed [SAMPLE_W-1:0]  rate_r, rate_nxt;
  logic signed [CW-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0]     ang_r, ang_nxt;
  logic signed [TILT_W-1:0]    tilt_r, tilt_nxt;
  logic signed [RG_W-1:0]      rg_r, rg_nxt;
  logic signed [KT_W-1:0]      kt_r, kt_nxt;
  logic signed [S2_W-1:0]      sum2_r, sum2_nxt;
  logic signed [T_W-1:0]       t_r, t_nxt;
  logic [KLO_W-1:0]            klo_r, klo_nxt;
  logic signed [KHI_W-1:0]     khi_r, khi_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic                        clip_r, clip_nxt;

  logic                        dir_pos;
  logic signed [CW-1:0]        xs, ys;
  logic signed [ANG_W-1:0]     atan_val;
  logic signed [ANG_W-1:0]     ang_c, ang_rnd, ang_q, ang_t;
  logic signed [S2_W-1:0]      old_sh;
  logic signed [RG_W-1:0]      rg_full;
  logic signed [KT_W-1:0]      kt_full;
  logic [KLO_W-1:0]            klo_full;
  logic signed [KHI_W-1:0]     khi_full;
  logic signed [R_W-1:0]       r_w;
  logic [TILT_W+RAW_W-1:0]     tilt_ext;

  assign sts.idle = (state_r == ST_IDLE);
  assign sts.done = (state_r == ST_DONE);

  // one CORDIC micro-rotation
  assign dir_pos  = !y_r[CW-1];
  assign xs       = x_r >>> cnt_r;
  assign ys       = y_r >>> cnt_r;
  assign atan_val = ANG_W'(ATAN_TAB[cnt_r]);

  // clamp to +-90 degrees, round half up to angle LSBs, clamp again
  always_comb begin
    ang_c = ang_r;
    if (ang_r > ANG_LIM) begin
      ang_c = ANG_LIM;
    end else if (ang_r < -ANG_LIM) begin
      ang_c = -ANG_LIM;
    end
    ang_rnd = ang_c + ANG_HALF;
    ang_q   = ang_rnd >>> SH;
    ang_t   = ang_q;
    if (ang_q > TILT_LIM) begin
      ang_t = TILT_LIM;
    end else if (ang_q < -TILT_LIM) begin
      ang_t = -TILT_LIM;
    end
  end

  // blend products, one per step
  assign old_sh   = {old_r[FILT_W-1], old_r, 16'h0000};
  assign rg_full  = rate_r * $signed({1'b0, gain});
  assign kt_full  = $signed({1'b0, k_eff}) * tilt_r;
  assign klo_full = k_eff * sum2_r[23:0];
  assign khi_full = $signed({1'b0, k_eff}) * $signed(sum2_r[S2_W-1:24]);
  assign r_w      = acc_r[ACC_W-1:32];

  // sequencer and datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    old_nxt   = old_r;
    zero_nxt  = zero_r;
    rate_nxt  = rate_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    ang_nxt   = ang_r;
    tilt_nxt  = tilt_r;
    rg_nxt    = rg_r;
    kt_nxt    = kt_r;
    sum2_nxt  = sum2_r;
    t_nxt     = t_r;
    klo_nxt   = klo_r;
    khi_nxt   = khi_r;
    acc_nxt   = acc_r;
    clip_nxt  = clip_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          zero_nxt  = z_zero;
          rate_nxt  = rate;
          x_nxt     = CW'(z_mag) <<< PRE_SHIFT;
          y_nxt     = CW'(a_fold) <<< PRE_SHIFT;
          ang_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (dir_pos) begin
          x_nxt   = x_r + ys;
          y_nxt   = y_r - xs;
          ang_nxt = ang_r + atan_val;
        end else begin
          x_nxt   = x_r - ys;
          y_nxt   = y_r + xs;
          ang_nxt = ang_r - atan_val;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IT) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // zero z means no usable tilt
        tilt_nxt  = zero_r ? '0 : TILT_W'(ang_t);
        rg_nxt    = rg_full;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        kt_nxt    = kt_full;
        sum2_nxt  = old_sh + S2_W'(rg_r);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        klo_nxt   = klo_full;
        t_nxt     = T_W'(kt_r) + T_W'(sum2_r);
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        khi_nxt   = khi_full;
        acc_nxt   = (ACC_W'(t_r) <<< 16) - ACC_W'($signed({1'b0, klo_r}));
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = acc_r - (ACC_W'(khi_r) <<< 24) + ACC_HALF;
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        clip_nxt = 1'b0;
        if (r_w > R_W'(FILT_MAX)) begin
          old_nxt  = FILT_MAX;
          clip_nxt = 1'b1;
        end else if (r_w < R_W'(FILT_MIN)) begin
          old_nxt  = FILT_MIN;
          clip_nxt = 1'b1;
        end else begin
          old_nxt  = FILT_W'(r_w);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (ctl.retire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      old_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      old_r   <= old_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= zero_nxt;
    rate_r <= rate_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    ang_r  <= ang_nxt;
    tilt_r <= tilt_nxt;
    rg_r   <= rg_nxt;
    kt_r   <= kt_nxt;
    sum2_r <= sum2_nxt;
    t_r    <= t_nxt;
    klo_r  <= klo_nxt;
    khi_r  <= khi_nxt;
    acc_r  <= acc_nxt;
    clip_r <= clip_nxt;
  end

  // results, raw tilt wrapped to the 16-bit field
  assign tilt_ext = {{RAW_W{tilt_r[TILT_W-1]}}, tilt_r};
  assign tilt_raw = tilt_ext[RAW_W-1:0];
  assign filt     = old_r;
  assign clip     = clip_r;

endmodule

[hw/rtl/tcf_back.sv]
// ----------------------------------------------------------------------------
// Tilt filter back end
// Pops queued samples, runs both axis lanes and holds the result beat.
// ----------------------------------------------------------------------------
module tcf_back import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_data,
  output logic              q_pop,
  input  logic [K_W-1:0]    blend_weight,
  input  logic [GAIN_W-1:0] gyro_gain,
  output logic              out_empty,
  input  logic              out_pop,
  output out_item_t         out_data
);

  lane_ctl_t               ctl;
  lane_sts_t               sts_x, sts_y;
  logic [K_W-1:0]          k_eff;
  logic signed [RAW_W-1:0] raw_x, raw_y;
  logic signed [FILT_W-1:0] filt_x, filt_y;
  logic                    clip_x, clip_y;
  logic                    lanes_idle, lanes_done, load_out;
  logic                    out_v_r, out_v_nxt;
  out_item_t               out_r, out_nxt;

  // weights above one act as one
  assign k_eff = (blend_weight > K_ONE) ? K_ONE : blend_weight;

  // lane control
  assign lanes_idle = sts_x.idle && sts_y.idle;
  assign lanes_done = sts_x.done && sts_y.done;
  assign q_pop      = lanes_idle && !q_empty;
  assign load_out   = lanes_done && (!out_v_r || out_pop);
  assign ctl.start  = q_pop;
  assign ctl.retire = load_out;

  tcf_lane #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sts      (sts_x),
    .z_zero   (q_data.z_zero),
    .z_mag    (q_data.z_mag),
    .a_fold   (q_data.ax_fold),
    .rate     (q_data.rate_x),
    .k_eff    (k_eff),
    .gain     (gyro_gain),
    .tilt_raw (raw_x),
    .filt     (filt_x),
    .clip     (clip_x)
  );

  tcf_lane #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sts      (sts_y),
    .z_zero   (q_data.z_zero),
    .z_mag    (q_data.z_mag),
    .a_fold   (q_data.ay_fold),
    .rate     (q_data.rate_y),
    .k_eff    (k_eff),
    .gain     (gyro_gain),
    .tilt_raw (raw_y),
    .filt     (filt_y),
    .clip     (clip_y)
  );

  // result beat register
  always_comb begin
    out_nxt.tilt_x_raw      = raw_x;
    out_nxt.tilt_x_filtered = filt_x;
    out_nxt.tilt_y_raw      = raw_y;
    out_nxt.tilt_y_filtered = filt_y;
    out_nxt.clipped         = clip_x || clip_y;
    out_v_nxt = out_v_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_empty = !out_v_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/tilt_complementary_filter_core.sv]
// ----------------------------------------------------------------------------
// Tilt complementary filter core
// Two-axis accelerometer tilt by CORDIC, blended with integrated gyro rate.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_push / in_full       in_item_t sample beat
//   out_     output     out_empty / out_pop     out_item_t result beat
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each sample occupies the back end until both axis lanes have finished it,
// set by the one-rotation-per-cycle CORDIC loop in each axis lane.
// A sample in flight and up to QUEUE_DEPTH + 1 more beats are held in front.
// Synchronous reset clears the filter state, queue and result register and
// restores the register defaults; no clearing pass follows.
// A waiting result stalls the back end; the front keeps taking beats until the queue fills.
// ----------------------------------------------------------------------------
`include "tilt_complementary_filter_core_macros.svh"

module tilt_complementary_filter_core import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              q_push, q_full, q_pop, q_empty;
  cmd_t              q_wdata, q_rdata;
  logic [K_W-1:0]    blend_weight_r, blend_weight_nxt;
  logic [GAIN_W-1:0] gyro_gain_r, gyro_gain_nxt;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_comb begin
    blend_weight_nxt = blend_weight_r;
    gyro_gain_nxt    = gyro_gain_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BLEND_WEIGHT: blend_weight_nxt = cfg_data[K_W-1:0];
        REG_GYRO_GAIN:    gyro_gain_nxt    = cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= BLEND_WEIGHT_RST;
      gyro_gain_r    <= GYRO_GAIN_RST;
    end else begin
      blend_weight_r <= blend_weight_nxt;
      gyro_gain_r    <= gyro_gain_nxt;
    end
  end

  tcf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wdata)
  );

  tcf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  tcf_back #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .blend_weight (blend_weight_r),
    .gyro_gain    (gyro_gain_r),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_data     (out_data)
  );

  // checks
  `TCF_ASSERT_HOLDS(a_full_from_queue, in_full, q_full, "input stalled with room in queue")
  `TCF_ASSERT_HOLDS(a_pop_nonempty, q_pop, !q_empty, "back end popped an empty queue")
  `TCF_ASSERT_AFTER(a_reset_empty, !rst_n, out_empty && q_empty, "beats left after reset")

endmodule

[tb/tilt_complementary_filter_core_test.sv]
// ----------------------------------------------------------------------------
// Tilt complementary filter core testbench
// Drives sample beats through the push/full queue port and predicts every
// result beat with a behavioural CORDIC tilt and blend model of its own.
// Results are popped with random stalls and compared field by field. The
// register port is exercised between phases, and one phase holds off the
// result side long enough to back the block up and stall its input.
// ----------------------------------------------------------------------------
module tilt_complementary_filter_core_test;
  import tcf_pkg::*;

  localparam int LIMIT_CYCLES = 800000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 116;
  localparam int ANGLE_LIMIT  = 90 << DEF_ANGLE_FRAC_BITS;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  in_item_t              in_data   = '0;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BLEND_WEIGHT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state and register copies
  logic [K_W-1:0]    weight_reg = BLEND_WEIGHT_RST;
  logic [GAIN_W-1:0] gain_reg   = GYRO_GAIN_RST;
  longint            angle_x    = 0;
  longint            angle_y    = 0;

  out_item_t pending_results[$];
  int        fail_count   = 0;
  int        cycle_count  = 0;
  bit        no_idle      = 1'b0;
  bit        hold_request = 1'b0;
  int        send_idle_odds = 8;

  tilt_complementary_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // vectoring CORDIC: atan(a / z) in angle LSBs, z folded onto the +x half
  function automatic longint cordic_tilt(longint a, longint z);
    longint x, y, xs, ys, ang, res;
    int     steps;
    if (z == 0) return 0;
    x     = (z < 0 ? -z : z) * (64'sd1 << PRE_SHIFT);
    y     = (z < 0 ? -a : a) * (64'sd1 << PRE_SHIFT);
    ang   = 0;
    steps = (DEF_CORDIC_STEPS < TAB_LEN) ? DEF_CORDIC_STEPS : TAB_LEN;
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        ang = ang + longint'(ATAN_TAB[i]);
      end else begin
        x   = x - ys;
        y   = y + xs;
        ang = ang - longint'(ATAN_TAB[i]);
      end
    end
    if (ang > (64'sd90 << TAB_FRAC))  ang = 64'sd90 << TAB_FRAC;
    if (ang < -(64'sd90 << TAB_FRAC)) ang = -(64'sd90 << TAB_FRAC);
    // round half up to angle LSBs
    res = (ang + ((64'sd1 << (TAB_FRAC - DEF_ANGLE_FRAC_BITS)) >>> 1))
          >>> (TAB_FRAC - DEF_ANGLE_FRAC_BITS);
    if (res > ANGLE_LIMIT)  res = ANGLE_LIMIT;
    if (res < -ANGLE_LIMIT) res = -ANGLE_LIMIT;
    return res;
  endfunction

  // k * tilt + (1 - k) * (prev + rate * gain), saturated to the filter width
  function automatic longint blend_axis(longint tilt, longint prev, longint rate,
                                        inout bit clip);
    longint k, acc, r;
    k   = (weight_reg > K_ONE) ? longint'(K_ONE) : longint'(weight_reg);
    acc = k * (tilt * 65536)
        + (65536 - k) * (prev * 65536 + rate * longint'(gain_reg));
    r   = (acc + (64'sd1 << 31)) >>> 32;
    if (r > longint'(FILT_MAX)) begin
      r    = longint'(FILT_MAX);
      clip = 1'b1;
    end
    if (r < longint'(FILT_MIN)) begin
      r    = longint'(FILT_MIN);
      clip = 1'b1;
    end
    return r;
  endfunction

  function automatic out_item_t predict_tilt_result(in_item_t s);
    out_item_t r;
    longint    tx, ty;
    bit        clip;
    clip    = 1'b0;
    tx      = cordic_tilt(longint'(s.accel_x), longint'(s.accel_z));
    ty      = cordic_tilt(longint'(s.accel_y), longint'(s.accel_z));
    angle_x = blend_axis(tx, angle_x, longint'(s.rate_x), clip);
    angle_y = blend_axis(ty, angle_y, longint'(s.rate_y), clip);
    r.tilt_x_raw      = tx[RAW_W-1:0];
    r.tilt_x_filtered = angle_x[FILT_W-1:0];
    r.tilt_y_raw      = ty[RAW_W-1:0];
    r.tilt_y_filtered = angle_y[FILT_W-1:0];
    r.clipped         = clip;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: checking and pop control
  // --------------------------------------------------------------------------

  task automatic report_field(string name, longint expv, longint actv);
    $display("%0t: mismatch on %s: expected %0d actual %0d", $time, name, expv, actv);
    fail_count++;
  endtask

  int stall_left = 0;
  int run_left   = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.tilt_x_raw !== want.tilt_x_raw)
          report_field("tilt_x_raw", want.tilt_x_raw, out_data.tilt_x_raw);
        if (out_data.tilt_x_filtered !== want.tilt_x_filtered)
          report_field("tilt_x_filtered", want.tilt_x_filtered, out_data.tilt_x_filtered);
        if (out_data.tilt_y_raw !== want.tilt_y_raw)
          report_field("tilt_y_raw", want.tilt_y_raw, out_data.tilt_y_raw);
        if (out_data.tilt_y_filtered !== want.tilt_y_filtered)
          report_field("tilt_y_filtered", want.tilt_y_filtered, out_data.tilt_y_filtered);
        if (out_data.clipped !== want.clipped)
          report_field("clipped", want.clipped, out_data.clipped);
      end
    end

    // long hold-off, counted here
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (stall_left > 0 && !no_idle) begin
      stall_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left = $urandom_range(0, 40);
        if (!no_idle && $urandom_range(0, 2) != 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side and register port
  // --------------------------------------------------------------------------

  task automatic send_sample(in_item_t s);
    in_push <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_full);
    pending_results.push_back(predict_tilt_result(s));
    if (!no_idle && $urandom_range(1, send_idle_odds) == 1) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BLEND_WEIGHT) weight_reg = d[K_W-1:0];
    else if (idx == REG_GYRO_GAIN) gain_reg = d[GAIN_W-1:0];
  endtask

  // both registers, only with nothing in flight
  task automatic configure(logic [CFG_DATA_W-1:0] k, logic [CFG_DATA_W-1:0] g);
    wait_drained();
    write_reg(REG_BLEND_WEIGHT, k);
    write_reg(REG_GYRO_GAIN, g);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_sample(shortint ax, shortint ay, shortint az,
                                           shortint rx, shortint ry);
    in_item_t s;
    s.accel_x = ax;
    s.accel_y = ay;
    s.accel_z = az;
    s.rate_x  = rx;
    s.rate_y  = ry;
    return s;
  endfunction

  function automatic shortint edge_value();
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      4:       return 16'sd32767;
      default: return shortint'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    shortint  az;
    case ($urandom_range(0, 9))
      0, 1, 2: s = in_item_t'({$urandom, $urandom, $urandom});
      3, 4, 5, 6: begin
        // board at rest or gently tilted, modest rates
        az = shortint'($urandom_range(8000, 16384));
        if ($urandom_range(0, 3) == 0) az = -az;
        s = make_sample(shortint'($urandom_range(0, 32768)) - 16'sd16384,
                        shortint'($urandom_range(0, 32768)) - 16'sd16384, az,
                        shortint'($urandom_range(0, 1000)) - 16'sd500,
                        shortint'($urandom_range(0, 1000)) - 16'sd500);
      end
      7: begin
        s = in_item_t'({$urandom, $urandom, $urandom});
        s.accel_z = '0;
      end
      default: s = make_sample(edge_value(), edge_value(), edge_value(),
                               edge_value(), edge_value());
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_reset_defaults();
    send_sample(make_sample(1000, -1000, 16384, 100, -100));
    send_sample(make_sample(0, 0, 0, 0, 0));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
  endtask

  task automatic test_tilt_extremes();
    configure(24'd32768, GYRO_GAIN_RST);
    // zero z gives zero tilt whatever the other axes read
    send_sample(make_sample(32767, -32768, 0, 0, 0));
    // steepest angles, clamped to a right angle, then diagonal and small angles
    send_sample(make_sample(32767, -32768, 1, 1, -1));
    send_sample(make_sample(-32768, 32767, -1, -32768, 32767));
    send_sample(make_sample(-32768, 0, -32768, 0, 0));
    send_sample(make_sample(0, 32767, 32767, 0, 0));
    send_sample(make_sample(0, 0, -1, 0, 0));
    send_sample(make_sample(1, -1, 32767, 0, 0));
    send_sample(make_sample(32767, 32767, -32768, 0, 0));
  endtask

  task automatic test_blend_weight();
    configure(CFG_DATA_W'(K_ONE), 24'd0);
    send_sample(make_sample(5000, -7000, 12000, 32767, -32768));
    send_sample(make_sample(-5000, 7000, -12000, 3, 4));
    // weights above one act as one
    configure(24'h01FFFF, 24'd10240);
    send_sample(make_sample(9000, 200, 9000, 32767, 32767));
    send_sample(make_sample(-200, -9000, 300, -32768, -32768));
    configure(24'hFFFFFF, 24'd1234);
    send_sample(make_sample(100, 200, 300, 400, 500));
    configure(24'd0, GYRO_GAIN_RST);
    send_sample(make_sample(16000, -16000, 100, 1000, -1000));
    send_sample(make_sample(0, 0, 16384, 0, 0));
  endtask

  task automatic test_filter_saturation();
    configure(24'd0, 24'hFFFFFF);
    repeat (3) send_sample(make_sample(0, 0, 16384, 32767, 32767));
    repeat (3) send_sample(make_sample(0, 0, 16384, -32768, -32768));
  endtask

  // result side held off while samples keep coming, then a full drain
  task automatic test_backpressure();
    configure(24'd6554, 24'd10240);
    hold_request = 1'b1;
    no_idle      = 1'b1;
    repeat (30) send_sample(random_sample());
    no_idle      = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] k, g;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       k = 24'd0;
        1:       k = CFG_DATA_W'(K_ONE);
        2:       k = CFG_DATA_W'($urandom);
        default: k = CFG_DATA_W'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 4))
        0:       g = 24'd0;
        1:       g = 24'hFFFFFF;
        2:       g = CFG_DATA_W'($urandom);
        default: g = CFG_DATA_W'($urandom_range(0, 20000));
      endcase
      configure(k, g);
      // last phase runs flat out
      if (p == RAND_PHASES - 1) no_idle = 1'b1;
      send_idle_odds = (p % 3 == 2) ? 64 : 6;
      repeat (PHASE_ITEMS) send_sample(random_sample());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tilt_complementary_filter_core test failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_tilt_extremes();
    test_blend_weight();
    test_filter_saturation();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    // catch any stray beat after the last one expected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tilt_complementary_filter_core test passed");
    end else begin
      $display("tilt_complementary_filter_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/tcf_pkg.sv
hw/rtl/tcf_fifo.sv
hw/rtl/tcf_front.sv
hw/rtl/tcf_lane.sv
hw/rtl/tcf_back.sv
hw/rtl/tilt_complementary_filter_core.sv
tb/tilt_complementary_filter_core_test.sv
